### design/ipd_pkg.sv
`default_nettype none

package ipd_pkg;

   // bytes held ahead of the checksum byte; one packet is this plus one
   localparam int unsigned WinLen = 14;
   localparam int unsigned WaitWidth = 4;
   localparam logic [7:0] PreambleReset = 8'h65;

   typedef logic [7:0] byte_type;

   // what the sliding window shows to the packet checker
   typedef struct packed {
      logic                   full;   // a candidate packet can be checked
      byte_type               sum;    // low byte of the sum of the window
      byte_type [WinLen-1:0]  bytes;  // index 0 is the oldest byte
   } window_view_type;

   typedef struct packed {
      logic [7:0]         seq_number;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic [7:0]         packet_gap;
      logic [31:0]        lost_total;
   } result_type;

endpackage

`default_nettype wire

### design/ipd_byte_if.sv
`default_nettype none

interface ipd_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### design/ipd_rsp_if.sv
`default_nettype none

interface ipd_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         seq_number;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic [7:0]         packet_gap;
   logic [31:0]        lost_total;

   modport source (
      output valid, input ready,
      output seq_number, output accel_x, output accel_y, output accel_z,
      output gyro_x, output gyro_y, output gyro_z,
      output packet_gap, output lost_total
   );
   modport sink (
      input valid, output ready,
      input seq_number, input accel_x, input accel_y, input accel_z,
      input gyro_x, input gyro_y, input gyro_z,
      input packet_gap, input lost_total
   );
endinterface

`default_nettype wire

### design/imu_packet_deframer_core.sv
// Channel  Port            Direction  Payload
// bytes    req_ch          in         rx_byte
// packets  rsp_ch          out        seq_number, accel/gyro x y z, packet_gap, lost_total
// preamble csr_wr_en/data  in         8-bit start-of-packet byte
//
// One byte per cycle while the result side is not stalled; a byte's result passes through
// the input register, then the result register.
// The window keeps a running checksum, so each byte needs one add, one subtract and a compare.
// Reset (synchronous) empties the pipe, the window fill count and the sequence state.
// A stalled result holds; the input register still takes a byte while the result waits, if it is empty.
`default_nettype none

module imu_packet_deframer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   ipd_byte_if.sink        req_ch,
   ipd_rsp_if.source       rsp_ch
);

   ipd_pkg::byte_type        preamble_ff;
   ipd_pkg::byte_type        byte_ff;
   logic                     in_valid_ff, in_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ipd_pkg::result_type      rsp_data_ff;
   ipd_pkg::result_type      result;
   ipd_pkg::window_view_type view;
   logic                     hit;
   logic                     advance;
   logic                     req_xfer;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= ipd_pkg::PreambleReset;
      end else if (csr_wr_en) begin
         preamble_ff <= csr_wr_data;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = hit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         byte_ff <= req_ch.rx_byte;
      end
      if (advance && hit) begin
         rsp_data_ff <= result;
      end
   end

   ipd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .shift   (advance),
      .rx_byte (byte_ff),
      .hit     (hit),
      .view    (view)
   );

   ipd_track u_track (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .preamble (preamble_ff),
      .rx_byte  (byte_ff),
      .view     (view),
      .hit      (hit),
      .result   (result)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.seq_number = rsp_data_ff.seq_number;
   assign rsp_ch.accel_x    = rsp_data_ff.accel_x;
   assign rsp_ch.accel_y    = rsp_data_ff.accel_y;
   assign rsp_ch.accel_z    = rsp_data_ff.accel_z;
   assign rsp_ch.gyro_x     = rsp_data_ff.gyro_x;
   assign rsp_ch.gyro_y     = rsp_data_ff.gyro_y;
   assign rsp_ch.gyro_z     = rsp_data_ff.gyro_z;
   assign rsp_ch.packet_gap = rsp_data_ff.packet_gap;
   assign rsp_ch.lost_total = rsp_data_ff.lost_total;

endmodule

`default_nettype wire

### design/ipd_window.sv
`default_nettype none

module ipd_window (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     shift,
   input  wire ipd_pkg::byte_type        rx_byte,
   input  wire logic                     hit,
   output ipd_pkg::window_view_type      view
);

   ipd_pkg::byte_type                win_ff [ipd_pkg::WinLen];
   ipd_pkg::byte_type                win_in [ipd_pkg::WinLen];
   ipd_pkg::byte_type                sum_ff, sum_in;
   logic [ipd_pkg::WaitWidth-1:0]    wait_ff, wait_in;
   logic                             filled_ff, filled_in;
   ipd_pkg::byte_type                drop;

   // the oldest byte only counts toward the running sum once it was written
   assign drop = filled_ff ? win_ff[0] : 8'h00;

   always_comb begin
      win_in    = win_ff;
      sum_in    = sum_ff;
      wait_in   = wait_ff;
      filled_in = filled_ff;
      if (shift) begin
         for (int i = 0; i < ipd_pkg::WinLen - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[ipd_pkg::WinLen-1] = rx_byte;
         sum_in = sum_ff + rx_byte - drop;
         if (wait_ff != '0) begin
            wait_in = wait_ff - 1'b1;
            if (wait_ff == ipd_pkg::WaitWidth'(1)) begin
               filled_in = 1'b1;
            end
         end else if (hit) begin
            wait_in = ipd_pkg::WaitWidth'(ipd_pkg::WinLen);
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         wait_ff   <= ipd_pkg::WaitWidth'(ipd_pkg::WinLen);
         filled_ff <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         wait_ff   <= wait_in;
         filled_ff <= filled_in;
      end
   end

   always_comb begin
      view.full = (wait_ff == '0);
      view.sum  = sum_ff;
      for (int i = 0; i < ipd_pkg::WinLen; i++) begin
         view.bytes[i] = win_ff[i];
      end
   end

endmodule

`default_nettype wire

### design/ipd_track.sv
`default_nettype none

module ipd_track (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire ipd_pkg::byte_type        preamble,
   input  wire ipd_pkg::byte_type        rx_byte,
   input  wire ipd_pkg::window_view_type view,
   output logic                          hit,
   output ipd_pkg::result_type           result
);

   logic [7:0]  expected_ff, expected_in;
   logic [31:0] lost_ff, lost_in;
   logic [7:0]  seq;
   logic [7:0]  gap;
   logic [32:0] lost_sum;
   logic [31:0] lost_next;

   assign hit = view.full && (view.bytes[0] == preamble) && (view.sum == rx_byte);

   assign seq       = view.bytes[1];
   assign gap       = seq - expected_ff;
   assign lost_sum  = {1'b0, lost_ff} + {25'd0, gap};
   assign lost_next = lost_sum[32] ? '1 : lost_sum[31:0];

   always_comb begin
      expected_in = expected_ff;
      lost_in     = lost_ff;
      if (fire && hit) begin
         expected_in = seq + 8'd1;
         lost_in     = lost_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         lost_ff     <= '0;
      end else begin
         expected_ff <= expected_in;
         lost_ff     <= lost_in;
      end
   end

   always_comb begin
      result.seq_number = seq;
      result.accel_x    = signed'({view.bytes[2],  view.bytes[3]});
      result.accel_y    = signed'({view.bytes[4],  view.bytes[5]});
      result.accel_z    = signed'({view.bytes[6],  view.bytes[7]});
      result.gyro_x     = signed'({view.bytes[8],  view.bytes[9]});
      result.gyro_y     = signed'({view.bytes[10], view.bytes[11]});
      result.gyro_z     = signed'({view.bytes[12], view.bytes[13]});
      result.packet_gap = gap;
      result.lost_total = lost_next;
   end

endmodule

`default_nettype wire

### design/ipd_checker.sv
`default_nettype none

module ipd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_seq,
   input wire logic [7:0]  rsp_gap,
   input wire logic [31:0] rsp_lost
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result keeps its fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seq) && $stable(rsp_gap)
         && $stable(rsp_lost))
      else $error("stalled result changed");

   // a fresh result follows a byte transfer through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a preceding byte transfer");

   // the byte side never blocks while the result side is free
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("byte side stalled with empty result register");

endmodule

bind imu_packet_deframer_core ipd_checker u_ipd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_seq   (rsp_ch.seq_number),
   .rsp_gap   (rsp_ch.packet_gap),
   .rsp_lost  (rsp_ch.lost_total)
);

`default_nettype wire
